// ===== src/bfg_pkg.sv =====
// Package: sizes and floating-point helper functions for the bf16 GEMV unit.
package bfg_pkg;

    localparam int VectorLength = 4096;
    localparam int IdxW         = $clog2(VectorLength);
    localparam logic [31:0] CanonNan = 32'h7FC0_0000;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } op_t;

    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sgn;
        logic [7:0]  ea;
        logic [28:0] s;
    } add_mid_t;

    function automatic logic [31:0] bf16_mul(logic [15:0] a, logic [15:0] b);
        logic               sgn;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [7:0]         ma;
        logic [7:0]         mb;
        logic [15:0]        p;
        logic [15:0]        pn;
        logic [4:0]         lz;
        logic signed [10:0] be;
        logic signed [10:0] shw;
        logic [49:0]        t;
        logic [23:0]        mant;
        logic               g;
        logic               st;
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        logic [30:0]        body;
        logic [31:0]        r;
        sgn    = a[15] ^ b[15];
        a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
        b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
        a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
        b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'd0);
        a_zero = (a[14:0] == 15'd0);
        b_zero = (b[14:0] == 15'd0);
        ea     = (a[14:7] == 8'd0) ? 8'd1 : a[14:7];
        eb     = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
        ma     = {(a[14:7] != 8'd0), a[6:0]};
        mb     = {(b[14:7] != 8'd0), b[6:0]};
        p      = ma * mb;
        lz     = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (p[i])
            begin
                lz = 5'(15 - i);
            end
        end
        pn   = p << lz;
        be   = 11'(ea) + 11'(eb) - 11'sd126 - 11'(lz);
        shw  = 11'sd1 - be;
        t    = {pn, 34'd0} >> shw[5:0];
        mant = t[49:26];
        g    = t[25];
        st   = |t[24:0];
        body = {8'd0, mant[22:0]} + 31'(g & (st | mant[0]));
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            r = CanonNan;
        end
        else if (a_inf || b_inf)
        begin
            r = {sgn, 8'hFF, 23'd0};
        end
        else if (a_zero || b_zero)
        begin
            r = {sgn, 31'd0};
        end
        else if (be >= 11'sd255)
        begin
            r = {sgn, 8'hFF, 23'd0};
        end
        else if (be >= 11'sd1)
        begin
            r = {sgn, be[7:0], pn[14:0], 8'd0};
        end
        else if (be < -11'sd24)
        begin
            r = {sgn, 31'd0};
        end
        else
        begin
            r = {sgn, body};
        end
        return r;
    endfunction

    // First half of the fp32 add: order by magnitude, align, add or subtract.
    function automatic add_mid_t fp32_add_align(logic [31:0] x, logic [31:0] y);
        logic [31:0] a;
        logic [31:0] b;
        logic        x_nan;
        logic        y_nan;
        logic        x_inf;
        logic        y_inf;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [7:0]  d;
        logic [4:0]  dc;
        logic [49:0] tmp;
        logic [27:0] aext;
        logic [27:0] bext;
        add_mid_t    m;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        if (x[30:0] >= y[30:0])
        begin
            a = x;
            b = y;
        end
        else
        begin
            a = y;
            b = x;
        end
        ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma   = {(a[30:23] != 8'd0), a[22:0]};
        mb   = {(b[30:23] != 8'd0), b[22:0]};
        d    = ea - eb;
        dc   = (d > 8'd31) ? 5'd31 : d[4:0];
        tmp  = {mb, 26'd0} >> dc;
        aext = {ma, 4'd0};
        bext = {tmp[49:23], |tmp[22:0]};
        if (a[31] == b[31])
        begin
            m.s = {1'b0, aext} + {1'b0, bext};
        end
        else
        begin
            m.s = {1'b0, aext} - {1'b0, bext};
        end
        m.sgn = a[31];
        m.ea  = ea;
        if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31])))
        begin
            m.special     = 1'b1;
            m.special_val = CanonNan;
        end
        else if (x_inf || y_inf)
        begin
            m.special     = 1'b1;
            m.special_val = a;
        end
        else if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0))
        begin
            m.special     = 1'b1;
            m.special_val = {x[31] & y[31], 31'd0};
        end
        else
        begin
            m.special     = 1'b0;
            m.special_val = 32'd0;
        end
        return m;
    endfunction

    // Second half of the fp32 add: normalize and round to nearest even.
    function automatic logic [31:0] fp32_add_norm(add_mid_t m);
        logic [4:0]  lz;
        logic [7:0]  shamt;
        logic [8:0]  e_after;
        logic [27:0] n;
        logic [7:0]  efield;
        logic [30:0] body;
        logic [31:0] r;
        lz = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (m.s[i])
            begin
                lz = 5'(27 - i);
            end
        end
        shamt = (8'(lz) < (m.ea - 8'd1)) ? 8'(lz) : (m.ea - 8'd1);
        if (m.s[28])
        begin
            n       = {m.s[28:2], m.s[1] | m.s[0]};
            e_after = 9'(m.ea) + 9'd1;
        end
        else
        begin
            n       = m.s[27:0] << shamt;
            e_after = 9'(m.ea) - 9'(shamt);
        end
        efield = n[27] ? e_after[7:0] : 8'd0;
        body   = {efield, n[26:4]} + 31'(n[3] & ((|n[2:0]) | n[4]));
        if (m.special)
        begin
            r = m.special_val;
        end
        else if (m.s == 29'd0)
        begin
            r = 32'd0;
        end
        else if (e_after >= 9'd255)
        begin
            r = {m.sgn, 8'hFF, 23'd0};
        end
        else
        begin
            r = {m.sgn, body};
        end
        return r;
    endfunction

    function automatic logic [15:0] fp32_to_fp16(logic [31:0] b);
        logic               sgn;
        logic [7:0]         ex;
        logic [22:0]        man;
        logic signed [9:0]  e;
        logic [14:0]        h;
        logic [12:0]        rem;
        logic [23:0]        m24;
        logic [4:0]         sh;
        logic [23:0]        hs;
        logic [23:0]        rs;
        logic [23:0]        half;
        logic [15:0]        r;
        sgn  = b[31];
        ex   = b[30:23];
        man  = b[22:0];
        e    = 10'(ex) - 10'sd112;
        m24  = {1'b1, man};
        sh   = 5'(10'sd14 - e);
        hs   = m24 >> sh;
        rs   = m24 & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        if (ex == 8'hFF)
        begin
            if (man != 23'd0)
            begin
                r = {sgn, 5'h1F, 1'b1, man[21:13]};
            end
            else
            begin
                r = {sgn, 15'h7C00};
            end
        end
        else if (e >= 10'sd31)
        begin
            r = {sgn, 15'h7C00};
        end
        else if (e >= 10'sd1)
        begin
            h   = {e[4:0], man[22:13]};
            rem = man[12:0];
            if ((rem > 13'h1000) || ((rem == 13'h1000) && h[0]))
            begin
                h = h + 15'd1;
            end
            r = {sgn, h};
        end
        else if (e < -10'sd10)
        begin
            r = {sgn, 15'd0};
        end
        else
        begin
            h = hs[14:0];
            if ((rs > half) || ((rs == half) && h[0]))
            begin
                h = h + 15'd1;
            end
            r = {sgn, h};
        end
        return r;
    endfunction

endpackage

// ===== src/bfg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bfg_ram #(
    parameter int Width = 16,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bf16_gemv_f32_accumulate_unit.sv =====
// Top level: bf16 matrix-vector product with fp32 accumulation and fp16 row results.
//
// channel  | handshake                   | payload
// item     | item_valid / item_ready     | operation, element_index, value_bits, row_last
// result   | result_valid / result_ready | result_bits
//
// A load leaves the unit idle; loads can follow back to back.
// A matrix element passes through store read, bf16 multiply, fp32 align and add, and
// normalize and round into the accumulator; the input waits until the accumulator is written.
// A last element adds the emit state, which registers its fp16 result and clears the accumulator.
// Reset clears the control state, the output valid and the accumulator to +0; the
// vector store is not cleared. A held result stalls the emit cycle and so the input.
module bf16_gemv_f32_accumulate_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic                     operation,
    input  logic [11:0]              element_index,
    input  logic [15:0]              value_bits,
    input  logic                     row_last,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [15:0]              result_bits
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_NORM,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic                        accept;
    logic                        ram_we;
    logic                        ram_re;
    logic                        out_free;
    logic [bfg_pkg::IdxW-1:0]    idx;
    logic [15:0]                 vec_rdata;
    logic [15:0]                 val_reg;
    logic                        last_reg;
    logic [31:0]                 prod_reg;
    bfg_pkg::add_mid_t           mid_reg;
    logic [31:0]                 acc_reg;
    logic                        result_valid_reg;
    logic [15:0]                 result_reg;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign idx        = element_index[bfg_pkg::IdxW-1:0];
    assign ram_we     = accept && (operation == bfg_pkg::OP_LOAD);
    assign ram_re     = accept && (operation == bfg_pkg::OP_MATRIX);
    assign out_free   = !result_valid_reg || result_ready;

    bfg_ram #(
        .Width(16),
        .Depth(bfg_pkg::VectorLength)
    ) u_vec (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx),
        .wdata(value_bits),
        .re   (ram_re),
        .raddr(idx),
        .rdata(vec_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            val_reg          <= 16'd0;
            last_reg         <= 1'b0;
            prod_reg         <= 32'd0;
            mid_reg          <= '0;
            acc_reg          <= 32'd0;
            result_valid_reg <= 1'b0;
            result_reg       <= 16'd0;
        end
        else
        begin
            if ((state_reg == ST_EMIT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (ram_re)
                    begin
                        val_reg   <= value_bits;
                        last_reg  <= row_last;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= bfg_pkg::bf16_mul(vec_rdata, val_reg);
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    mid_reg   <= bfg_pkg::fp32_add_align(acc_reg, prod_reg);
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    acc_reg   <= bfg_pkg::fp32_add_norm(mid_reg);
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        result_reg <= bfg_pkg::fp32_to_fp16(acc_reg);
                        acc_reg    <= 32'd0;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_bits  = result_reg;

`ifndef SYNTHESIS
    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("vector store read and write in one cycle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |=> result_valid_reg && $stable(result_reg))
        else $error("waiting result dropped or changed");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_free |=> acc_reg == 32'd0)
        else $error("accumulator not cleared after row end");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !item_ready)
        else $error("input open while an element is in flight");
`endif

endmodule
